@@ src/jet_pkg.sv @@
// ----------------------------------------------------------------------------
// jet_pkg: shared types and constants of the Julia escape-time block
// Fixed-point format, register indexes, limb split of the multiplier row and
// the structs that travel between the controller, the row and its cells.
// ----------------------------------------------------------------------------
package jet_pkg;

  // Q4.28 operands and results.
  localparam int FRAC_BITS = 28;
  localparam int DATA_W    = 32;
  localparam int LIMIT_W   = 11;
  localparam int RADIUS_W  = 40;

  // Largest number of rounds run for one item.
  localparam logic [LIMIT_W-1:0] MAX_LIMIT = 11'd1024;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_C_REAL     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_C_IMAG     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ITER_LIMIT = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RADIUS_SQ  = 2'd3;

  // A point that has not escaped stays inside +/-2^41 raw, and only a
  // magnitude below 2^34 can pass the escape test.
  localparam int Z_W   = 42;
  localparam int MAG_W = 34;

  // Multiplier row: operands split into limbs, one limb per cell.
  localparam int LIMB_W    = 12;
  localparam int NUM_CELLS = 3;
  localparam int OPND_W    = NUM_CELLS * LIMB_W;
  localparam int PROD_W    = 2 * OPND_W;
  localparam int ACC_W     = LIMB_W + 1;
  localparam int SUM_W     = PROD_W + 1;
  localparam int STEP_W    = $clog2(NUM_CELLS);

  typedef logic [LIMB_W-1:0] limb_t;
  typedef logic [ACC_W-1:0]  acc_t;
  typedef logic [OPND_W-1:0] opnd_t;
  typedef logic [PROD_W-1:0] prod_t;

  // Low digits handed from a cell to its less significant neighbor.
  typedef struct packed {
    limb_t rr;
    limb_t ii;
    limb_t ri;
  } jet_digits_t;

  // Row control: advance one limb, and begin a new product on this limb.
  typedef struct packed {
    logic step;
    logic start;
  } jet_row_ctrl_t;

  // Finished magnitudes of re*re, im*im and re*im.
  typedef struct packed {
    prod_t rr;
    prod_t ii;
    prod_t ri;
  } jet_prods_t;

endpackage

@@ src/jet_if.sv @@
// ----------------------------------------------------------------------------
// jet_if: item channels of the Julia escape-time block
// Ready/valid channels for starting points and for escape counts.
// ----------------------------------------------------------------------------
interface jet_point_if;
  import jet_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] start_real;
  logic signed [DATA_W-1:0] start_imag;

  modport source (output valid, output start_real, output start_imag, input ready);
  modport sink   (input valid, input start_real, input start_imag, output ready);
endinterface

interface jet_count_if;
  import jet_pkg::*;

  logic               valid;
  logic               ready;
  logic [LIMIT_W-1:0] escape_count;

  modport source (output valid, output escape_count, input ready);
  modport sink   (input valid, input escape_count, output ready);
endinterface

@@ src/julia_escape_time_top.sv @@
// ----------------------------------------------------------------------------
// julia_escape_time_top: Julia set escape-time iteration
// Each item on the points channel is a starting point z0 in signed Q4.28.
// The block repeats z = z*z + c and returns on the counts channel the
// 0-based round in which re^2 + im^2 first exceeds escape_radius_sq, or the
// round limit when z stays bounded. Both channels are valid/ready; the
// configuration port writes c_real, c_imag, iteration_limit and
// escape_radius_sq by index and should be used only while the block is idle.
// One point is worked on at a time. Every pass over z takes magnitudes,
// runs them through the three-cell multiplier row (one 12-bit limb per
// cycle), assembles the products and then tests and updates. An escaping
// point runs escape_count + 2 passes, a bounded one limit + 1; after the
// last pass the result is loaded into the output register once it is free.
// The default round limit is 128.
// Reset restores the register defaults and empties the output register.
// A finished result waits in the output register while the receiver stalls;
// the next point is taken meanwhile, and if it finishes before the old
// result is taken, it waits in the core until the register frees up.
// ----------------------------------------------------------------------------
module julia_escape_time_top (
  input  logic                            clk,
  input  logic                            rst,
  jet_point_if.sink                       points,
  jet_count_if.source                     counts,
  input  logic                            cfg_we,
  input  logic [jet_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [jet_pkg::RADIUS_W-1:0]    cfg_data
);
  import jet_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_PREP = 3'd1;
  localparam logic [2:0] ST_MUL  = 3'd2;
  localparam logic [2:0] ST_RES  = 3'd3;
  localparam logic [2:0] ST_UPD  = 3'd4;
  localparam logic [2:0] ST_DONE = 3'd5;

  logic [2:0]               state;
  logic [2:0]               state_next;

  // Configuration registers.
  logic signed [DATA_W-1:0] c_real;
  logic signed [DATA_W-1:0] c_imag;
  logic [LIMIT_W-1:0]       iteration_limit;
  logic [RADIUS_W-1:0]      escape_radius_sq;

  // Iteration state.
  logic signed [Z_W-1:0]    z_re;
  logic signed [Z_W-1:0]    z_im;
  logic [LIMIT_W-1:0]       k;
  logic [LIMIT_W-1:0]       limit_eff;
  logic [LIMIT_W-1:0]       result_count;
  logic [STEP_W-1:0]        step_cnt;

  // Operands of the current pass.
  logic [Z_W-1:0]           abs_re;
  logic [Z_W-1:0]           abs_im;
  opnd_t                    mag_re;
  opnd_t                    mag_im;
  logic                     big;
  logic                     neg_prod;

  // Products and update arithmetic.
  jet_row_ctrl_t            row_ctrl;
  limb_t                    b_re;
  limb_t                    b_im;
  jet_prods_t               prods;
  prod_t                    p_rr;
  prod_t                    p_ii;
  logic signed [SUM_W-1:0]  p_ri;
  logic [SUM_W-1:0]         p_ri_ext;
  logic [SUM_W-1:0]         sum_sq;
  logic [SUM_W-1:0]         thresh;
  logic signed [SUM_W-1:0]  diff;
  logic signed [SUM_W-1:0]  re_sh;
  logic signed [SUM_W-1:0]  im_sh;
  logic [Z_W-1:0]           c_re_ext;
  logic [Z_W-1:0]           c_im_ext;
  logic [Z_W-1:0]           re_next;
  logic [Z_W-1:0]           im_next;
  logic                     escaped;
  logic                     at_limit;

  // Output register.
  logic                     out_valid;
  logic [LIMIT_W-1:0]       out_count;
  logic                     accept;
  logic                     load_out;

  assign points.ready        = (state == ST_IDLE);
  assign accept              = points.valid && (state == ST_IDLE);
  assign load_out            = (state == ST_DONE) && (!out_valid || counts.ready);
  assign counts.valid        = out_valid;
  assign counts.escape_count = out_count;

  // Magnitudes of z; only the low MAG_W bits ever reach the multiplier, any
  // higher bit already means an escape.
  always_comb begin
    abs_re = z_re[Z_W-1] ? (~z_re + Z_W'(1)) : z_re;
    abs_im = z_im[Z_W-1] ? (~z_im + Z_W'(1)) : z_im;
  end

  // The row consumes one limb of the multiplier per cycle, lowest first.
  always_comb begin
    row_ctrl.step  = (state == ST_MUL);
    row_ctrl.start = (state == ST_MUL) && (step_cnt == '0);
    b_re           = mag_re[step_cnt*LIMB_W +: LIMB_W];
    b_im           = mag_im[step_cnt*LIMB_W +: LIMB_W];
  end

  jet_row u_row (
    .clk   (clk),
    .rst   (rst),
    .ctrl  (row_ctrl),
    .a_re  (mag_re),
    .a_im  (mag_im),
    .b_re  (b_re),
    .b_im  (b_im),
    .prods (prods)
  );

  // Escape test on the current z and the next z from its products. The
  // test is skipped for z0, since round i tests the z that it produced.
  always_comb begin
    p_ri_ext = {1'b0, prods.ri};
    sum_sq   = {1'b0, p_rr} + {1'b0, p_ii};
    thresh   = SUM_W'({escape_radius_sq, {FRAC_BITS{1'b0}}});
    diff     = {1'b0, p_rr} - {1'b0, p_ii};
    re_sh    = diff >>> FRAC_BITS;
    im_sh    = p_ri >>> (FRAC_BITS - 1);
    c_re_ext = {{(Z_W-DATA_W){c_real[DATA_W-1]}}, c_real};
    c_im_ext = {{(Z_W-DATA_W){c_imag[DATA_W-1]}}, c_imag};
    re_next  = re_sh[Z_W-1:0] + c_re_ext;
    im_next  = im_sh[Z_W-1:0] + c_im_ext;
    escaped  = (k != '0) && (big || (sum_sq > thresh));
    at_limit = (k == limit_eff);
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = ST_PREP;
        end
      end
      ST_PREP: begin
        state_next = ST_MUL;
      end
      ST_MUL: begin
        if (step_cnt == STEP_W'(NUM_CELLS - 1)) begin
          state_next = ST_RES;
        end
      end
      ST_RES: begin
        state_next = ST_UPD;
      end
      ST_UPD: begin
        if (escaped || at_limit) begin
          state_next = ST_DONE;
        end else begin
          state_next = ST_PREP;
        end
      end
      ST_DONE: begin
        if (load_out) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Control and configuration.
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= ST_IDLE;
      step_cnt         <= '0;
      out_valid        <= 1'b0;
      c_real           <= -32'sd241591910;
      c_imag           <= 32'sd107374182;
      iteration_limit  <= 11'd128;
      escape_radius_sq <= 40'd26843545600;
    end else begin
      state <= state_next;

      if (state == ST_MUL) begin
        step_cnt <= step_cnt + STEP_W'(1);
      end else begin
        step_cnt <= '0;
      end

      if (load_out) begin
        out_valid <= 1'b1;
      end else if (counts.ready) begin
        out_valid <= 1'b0;
      end

      if (cfg_we) begin
        case (cfg_index)
          REG_C_REAL:     c_real           <= cfg_data[DATA_W-1:0];
          REG_C_IMAG:     c_imag           <= cfg_data[DATA_W-1:0];
          REG_ITER_LIMIT: iteration_limit  <= cfg_data[LIMIT_W-1:0];
          REG_RADIUS_SQ:  escape_radius_sq <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (accept) begin
          z_re      <= {{(Z_W-DATA_W){points.start_real[DATA_W-1]}}, points.start_real};
          z_im      <= {{(Z_W-DATA_W){points.start_imag[DATA_W-1]}}, points.start_imag};
          k         <= '0;
          limit_eff <= (iteration_limit > MAX_LIMIT) ? MAX_LIMIT : iteration_limit;
        end
      end
      ST_PREP: begin
        mag_re   <= {{(OPND_W-MAG_W){1'b0}}, abs_re[MAG_W-1:0]};
        mag_im   <= {{(OPND_W-MAG_W){1'b0}}, abs_im[MAG_W-1:0]};
        big      <= (|abs_re[Z_W-1:MAG_W]) || (|abs_im[Z_W-1:MAG_W]);
        neg_prod <= z_re[Z_W-1] ^ z_im[Z_W-1];
      end
      ST_RES: begin
        p_rr <= prods.rr;
        p_ii <= prods.ii;
        p_ri <= neg_prod ? (~p_ri_ext + SUM_W'(1)) : p_ri_ext;
      end
      ST_UPD: begin
        if (escaped) begin
          result_count <= k - LIMIT_W'(1);
        end else if (at_limit) begin
          result_count <= limit_eff;
        end else begin
          z_re <= re_next;
          z_im <= im_next;
          k    <= k + LIMIT_W'(1);
        end
      end
      default: ;
    endcase

    if (load_out) begin
      out_count <= result_count;
    end
  end

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    points.valid && points.ready |=> state == ST_PREP && k == '0)
    else $error("accepted point did not start at round zero");

  a_round_bound: assert property (@(posedge clk) disable iff (rst)
    state != ST_IDLE |-> k <= limit_eff)
    else $error("round counter passed the limit");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    load_out |-> result_count <= limit_eff)
    else $error("escape count above the limit");

  a_done_drains: assert property (@(posedge clk) disable iff (rst)
    state == ST_DONE && !out_valid |=> state == ST_IDLE && out_valid)
    else $error("finished result not moved to the output register");

endmodule

@@ src/jet_cell.sv @@
// ----------------------------------------------------------------------------
// jet_cell: one limb cell of the multiplier row
// Holds one limb of each product's partial sum, multiplies its limbs by the
// broadcast limb, passes the low digit down and keeps the carry.
// ----------------------------------------------------------------------------
module jet_cell (
  input  logic                  clk,
  input  logic                  rst,
  input  jet_pkg::jet_row_ctrl_t ctrl,
  input  jet_pkg::limb_t        a_re,
  input  jet_pkg::limb_t        a_im,
  input  jet_pkg::limb_t        b_re,
  input  jet_pkg::limb_t        b_im,
  input  jet_pkg::jet_digits_t  digits_in,
  output jet_pkg::jet_digits_t  digits_out,
  output jet_pkg::acc_t         acc_rr,
  output jet_pkg::acc_t         acc_ii,
  output jet_pkg::acc_t         acc_ri
);
  import jet_pkg::*;

  acc_t                rr;
  acc_t                ii;
  acc_t                ri;
  acc_t                rr_next;
  acc_t                ii_next;
  acc_t                ri_next;
  acc_t                base_rr;
  acc_t                base_ii;
  acc_t                base_ri;
  logic [2*LIMB_W-1:0] p_rr;
  logic [2*LIMB_W-1:0] p_ii;
  logic [2*LIMB_W-1:0] p_ri;
  logic [2*LIMB_W:0]   u_rr;
  logic [2*LIMB_W:0]   u_ii;
  logic [2*LIMB_W:0]   u_ri;

  always_comb begin
    // A new product starts from an empty partial sum.
    base_rr = ctrl.start ? '0 : rr;
    base_ii = ctrl.start ? '0 : ii;
    base_ri = ctrl.start ? '0 : ri;

    p_rr = a_re * b_re;
    p_ii = a_im * b_im;
    p_ri = a_re * b_im;

    u_rr = {1'b0, p_rr} + {{(LIMB_W){1'b0}}, base_rr};
    u_ii = {1'b0, p_ii} + {{(LIMB_W){1'b0}}, base_ii};
    u_ri = {1'b0, p_ri} + {{(LIMB_W){1'b0}}, base_ri};

    digits_out.rr = u_rr[LIMB_W-1:0];
    digits_out.ii = u_ii[LIMB_W-1:0];
    digits_out.ri = u_ri[LIMB_W-1:0];

    // The carry stays here, the next limb's low digit moves in.
    rr_next = u_rr[2*LIMB_W:LIMB_W] + {1'b0, digits_in.rr};
    ii_next = u_ii[2*LIMB_W:LIMB_W] + {1'b0, digits_in.ii};
    ri_next = u_ri[2*LIMB_W:LIMB_W] + {1'b0, digits_in.ri};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rr <= '0;
      ii <= '0;
      ri <= '0;
    end else if (ctrl.step) begin
      rr <= rr_next;
      ii <= ii_next;
      ri <= ri_next;
    end
  end

  assign acc_rr = rr;
  assign acc_ii = ii;
  assign acc_ri = ri;

endmodule

@@ src/jet_row.sv @@
// ----------------------------------------------------------------------------
// jet_row: limb-serial multiplier built from a chain of cells
// Forms re*re, im*im and re*im together: one multiplier limb enters per
// step, the low product digits leave at the bottom cell, and the partial
// sums left in the cells give the upper half.
// ----------------------------------------------------------------------------
module jet_row (
  input  logic                   clk,
  input  logic                   rst,
  input  jet_pkg::jet_row_ctrl_t ctrl,
  input  jet_pkg::opnd_t         a_re,
  input  jet_pkg::opnd_t         a_im,
  input  jet_pkg::limb_t         b_re,
  input  jet_pkg::limb_t         b_im,
  output jet_pkg::jet_prods_t    prods
);
  import jet_pkg::*;

  jet_digits_t       link [NUM_CELLS+1];
  acc_t              acc_rr [NUM_CELLS];
  acc_t              acc_ii [NUM_CELLS];
  acc_t              acc_ri [NUM_CELLS];
  opnd_t             low_rr;
  opnd_t             low_ii;
  opnd_t             low_ri;
  logic [OPND_W:0]   hi_rr;
  logic [OPND_W:0]   hi_ii;
  logic [OPND_W:0]   hi_ri;

  // Nothing enters above the most significant cell.
  assign link[NUM_CELLS] = '0;

  for (genvar j = 0; j < NUM_CELLS; j++) begin : g_cell
    jet_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctrl       (ctrl),
      .a_re       (a_re[j*LIMB_W +: LIMB_W]),
      .a_im       (a_im[j*LIMB_W +: LIMB_W]),
      .b_re       (b_re),
      .b_im       (b_im),
      .digits_in  (link[j+1]),
      .digits_out (link[j]),
      .acc_rr     (acc_rr[j]),
      .acc_ii     (acc_ii[j]),
      .acc_ri     (acc_ri[j])
    );
  end

  // Low digits arrive least significant first.
  always_ff @(posedge clk) begin
    if (ctrl.step) begin
      low_rr <= {link[0].rr, low_rr[OPND_W-1:LIMB_W]};
      low_ii <= {link[0].ii, low_ii[OPND_W-1:LIMB_W]};
      low_ri <= {link[0].ri, low_ri[OPND_W-1:LIMB_W]};
    end
  end

  always_comb begin
    hi_rr = '0;
    hi_ii = '0;
    hi_ri = '0;
    for (int j = 0; j < NUM_CELLS; j++) begin
      hi_rr = hi_rr + ((OPND_W+1)'(acc_rr[j]) << (j*LIMB_W));
      hi_ii = hi_ii + ((OPND_W+1)'(acc_ii[j]) << (j*LIMB_W));
      hi_ri = hi_ri + ((OPND_W+1)'(acc_ri[j]) << (j*LIMB_W));
    end
    prods.rr = {hi_rr[OPND_W-1:0], low_rr};
    prods.ii = {hi_ii[OPND_W-1:0], low_ii};
    prods.ri = {hi_ri[OPND_W-1:0], low_ri};
  end

  // The running upper half never exceeds the width of one operand.
  a_upper_fits: assert property (@(posedge clk) disable iff (rst)
    !hi_rr[OPND_W] && !hi_ii[OPND_W] && !hi_ri[OPND_W])
    else $error("multiplier row upper half overflowed");

endmodule

@@ sim/tb_julia_escape_time_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_julia_escape_time_top: self-checking bench for the Julia escape-time block
// Starting points are driven through the points channel. Every accepted item
// is run through a local fixed-point escape-time predictor. Each escape count
// that comes back is checked against the oldest prediction. The run walks
// through several register settings, from a zero round limit up to the
// saturated one, and through several patterns of sender and receiver idling.
// ----------------------------------------------------------------------------
module tb_julia_escape_time_top;
  import jet_pkg::*;

  // The watchdog limit lies beyond the slowest legal run, in which every
  // point stays bounded at its round limit.
  localparam int CYCLE_LIMIT      = 6_000_000;
  localparam int TAIL_CYCLES      = 40;
  localparam int RANDOM_PHASES    = 8;
  localparam int POINTS_PER_PHASE = 175;
  localparam int SHOWN_MISMATCHES = 10;

  // One in Q4.28, and the corners of the signed coordinate range.
  localparam int ONE = 1 << FRAC_BITS;
  localparam logic signed [DATA_W-1:0] Q_MAX = 32'sh7fff_ffff;
  localparam logic signed [DATA_W-1:0] Q_MIN = 32'sh8000_0000;

  // Register defaults after reset: c = -0.9 + 0.4i, 128 rounds, radius^2 = 100.
  localparam logic signed [DATA_W-1:0] DEF_C_RE   = -32'sd241591910;
  localparam logic signed [DATA_W-1:0] DEF_C_IM   = 32'sd107374182;
  localparam logic [LIMIT_W-1:0]       DEF_LIMIT  = 11'd128;
  localparam logic [RADIUS_W-1:0]      DEF_RADIUS = 40'd26843545600;
  localparam logic [RADIUS_W-1:0]      RADIUS_4   = 40'd1 << (2 * FRAC_BITS - 26);

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] re;
    logic signed [DATA_W-1:0] im;
  } point_t;

  // A predicted escape count together with the point it belongs to.
  typedef struct packed {
    point_t             z0;
    logic [LIMIT_W-1:0] count;
  } escape_t;

  logic                 clk;
  logic                 rst;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [RADIUS_W-1:0]  cfg_data;

  jet_point_if points ();
  jet_count_if counts ();

  julia_escape_time_top u_dut (
    .clk       (clk),
    .rst       (rst),
    .points    (points),
    .counts    (counts),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Local copy of the Julia constant, the round limit and the squared radius.
  // It changes only while the block is idle, so predictions made at the
  // acceptance edge always see the setting that the block itself uses.
  logic signed [DATA_W-1:0] julia_c_re  = DEF_C_RE;
  logic signed [DATA_W-1:0] julia_c_im  = DEF_C_IM;
  logic [LIMIT_W-1:0]       round_limit = DEF_LIMIT;
  logic [RADIUS_W-1:0]      radius_sq   = DEF_RADIUS;

  point_t  point_backlog[$];     // points waiting to be offered
  escape_t pending_escapes[$];   // predictions waiting for their result

  int sender_idle_pct    = 0;
  int receiver_stall_pct = 0;
  logic took_point = 1'b0;       // the offered point was accepted last edge

  int cycle_count    = 0;
  int points_taken   = 0;
  int counts_checked = 0;
  int bounded_points = 0;
  int settings_used  = 1;
  int mismatch_count = 0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Predictor. The orbit is carried in 128-bit signed values, which hold every
  // square and product exactly. Each round squares z, floors the rescaled
  // parts with an arithmetic shift, adds c, and then tests re^2 + im^2 against
  // the squared radius moved up to the scale of a product. The test is strict.
  // A limit above the largest supported one is clamped to it, and a zero limit
  // runs no round at all and answers zero.
  // --------------------------------------------------------------------------
  function automatic logic [LIMIT_W-1:0] escape_round(point_t z0);
    logic signed [127:0] re;
    logic signed [127:0] im;
    logic signed [127:0] next_re;
    logic signed [127:0] next_im;
    logic signed [127:0] mag_sq;
    logic signed [127:0] threshold;
    int rounds;
    int escaped_at;
    rounds     = (round_limit > MAX_LIMIT) ? int'(MAX_LIMIT) : int'(round_limit);
    escaped_at = rounds;
    threshold  = '0;
    threshold[RADIUS_W+FRAC_BITS-1:0] = {radius_sq, {FRAC_BITS{1'b0}}};
    re = z0.re;
    im = z0.im;
    for (int k = 0; k < rounds && escaped_at == rounds; k++) begin
      // The imaginary part is 2*re*im, so it is shifted one bit less.
      next_re = ((re * re - im * im) >>> FRAC_BITS) + julia_c_re;
      next_im = ((re * im) >>> (FRAC_BITS - 1)) + julia_c_im;
      re      = next_re;
      im      = next_im;
      mag_sq  = re * re + im * im;
      if (mag_sq > threshold) begin
        escaped_at = k;
      end
    end
    return LIMIT_W'(escaped_at);
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers.
  // --------------------------------------------------------------------------
  function automatic logic signed [DATA_W-1:0] to_q(real value);
    return $rtoi(value * 268435456.0);
  endfunction

  function automatic logic signed [DATA_W-1:0] corner_coord();
    case ($urandom_range(4))
      0:       return Q_MIN;
      1:       return Q_MAX;
      2:       return '0;
      3:       return -32'sd1;
      default: return 32'sd1;
    endcase
  endfunction

  // Most points lie in the box |re|, |im| <= 2, where orbits run long and
  // escape counts spread out. Some sit near the origin, some anywhere in the
  // signed range, which flips every input bit, and a few on the corners.
  function automatic point_t random_point();
    point_t p;
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 65) begin
      p.re = DATA_W'(int'($urandom_range(0, 1 << 30)) - (1 << 29));
      p.im = DATA_W'(int'($urandom_range(0, 1 << 30)) - (1 << 29));
    end else if (pick < 80) begin
      p.re = DATA_W'(int'($urandom_range(0, 1 << 28)) - (1 << 27));
      p.im = DATA_W'(int'($urandom_range(0, 1 << 28)) - (1 << 27));
    end else if (pick < 95) begin
      p.re = $urandom;
      p.im = $urandom;
    end else begin
      p.re = corner_coord();
      p.im = corner_coord();
    end
    return p;
  endfunction

  task automatic queue_point(input logic signed [DATA_W-1:0] re,
                             input logic signed [DATA_W-1:0] im);
    point_t p;
    p.re = re;
    p.im = im;
    point_backlog.push_back(p);
  endtask

  // One register write per cycle, starting at a falling edge. The local copy
  // follows the write right away; the block is idle whenever this runs.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] index,
                           input logic [RADIUS_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value;
    case (index)
      REG_C_REAL:     julia_c_re  = value[DATA_W-1:0];
      REG_C_IMAG:     julia_c_im  = value[DATA_W-1:0];
      REG_ITER_LIMIT: round_limit = value[LIMIT_W-1:0];
      REG_RADIUS_SQ:  radius_sq   = value;
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic set_julia(input logic signed [DATA_W-1:0] c_re,
                           input logic signed [DATA_W-1:0] c_im,
                           input logic [LIMIT_W-1:0] limit,
                           input logic [RADIUS_W-1:0] radius);
    write_reg(REG_C_REAL, c_re);
    write_reg(REG_C_IMAG, c_im);
    write_reg(REG_ITER_LIMIT, limit);
    write_reg(REG_RADIUS_SQ, radius);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  // A random setting: c is either a well-known Julia constant or a random
  // value, mostly with |re|, |im| <= 2. Limits stay moderate so that bounded
  // points do not dominate the run; the squared radius ranges from zero to huge.
  task automatic random_setting();
    logic signed [DATA_W-1:0] c_re;
    logic signed [DATA_W-1:0] c_im;
    logic [LIMIT_W-1:0]       limit;
    logic [RADIUS_W-1:0]      radius;
    int unsigned              pick;
    pick = $urandom_range(99);
    if (pick < 50) begin
      case ($urandom_range(5))
        0:       begin c_re = to_q(-0.8);    c_im = to_q(0.156);   end
        1:       begin c_re = to_q(0.285);   c_im = to_q(0.01);    end
        2:       begin c_re = to_q(-0.4);    c_im = to_q(0.6);     end
        3:       begin c_re = to_q(-0.7269); c_im = to_q(0.1889);  end
        4:       begin c_re = to_q(0.0);     c_im = to_q(0.8);     end
        default: begin c_re = to_q(-0.835);  c_im = to_q(-0.2321); end
      endcase
    end else if (pick < 90) begin
      c_re = DATA_W'(int'($urandom_range(0, 1 << 30)) - (1 << 29));
      c_im = DATA_W'(int'($urandom_range(0, 1 << 30)) - (1 << 29));
    end else begin
      c_re = $urandom;
      c_im = $urandom;
    end

    pick = $urandom_range(99);
    if (pick < 10) begin
      limit = 11'd1;
    end else if (pick < 20) begin
      limit = LIMIT_W'($urandom_range(2, 8));
    end else begin
      limit = LIMIT_W'($urandom_range(9, 160));
    end

    pick = $urandom_range(99);
    if (pick < 25) begin
      radius = RADIUS_4;
    end else if (pick < 50) begin
      radius = DEF_RADIUS;
    end else if (pick < 70) begin
      radius = {8'($urandom), 32'($urandom)};
    end else if (pick < 90) begin
      radius = RADIUS_W'({2'($urandom), 32'($urandom)});
    end else begin
      radius = '0;
    end
    set_julia(c_re, c_im, limit, radius);
  endtask

  // Sets the idling pattern, then waits until every queued point has been
  // accepted and every predicted result has come back.
  task automatic run_points(input idle_mode_t mode);
    case (mode)
      IDLE_NONE:     begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
      IDLE_SENDER:   begin sender_idle_pct = 72; receiver_stall_pct = 0;  end
      IDLE_RECEIVER: begin sender_idle_pct = 0;  receiver_stall_pct = 72; end
      default:       begin sender_idle_pct = 6;  receiver_stall_pct = 6;  end
    endcase
    while (point_backlog.size() != 0 || points.valid || pending_escapes.size() != 0) begin
      @(negedge clk);
    end
  endtask

  task automatic note_mismatch(input string what, input escape_t want);
    mismatch_count++;
    if (mismatch_count <= SHOWN_MISMATCHES) begin
      $display("mismatch at cycle %0d: %s, z0 = (%0d, %0d), expected %0d, got %0d",
               cycle_count, what, want.z0.re, want.z0.im, want.count, counts.escape_count);
    end
  endtask

  // --------------------------------------------------------------------------
  // Point driver. Inputs change on the falling edge only. A point stays on the
  // channel until the rising edge that accepts it; after that the next one may
  // follow at once, or the channel goes quiet for a while.
  // --------------------------------------------------------------------------
  always @(negedge clk) begin : point_driver
    point_t next_point;
    if (rst) begin
      points.valid <= 1'b0;
    end else if (!points.valid || took_point) begin
      if (point_backlog.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
        next_point         = point_backlog.pop_front();
        points.valid      <= 1'b1;
        points.start_real <= next_point.re;
        points.start_imag <= next_point.im;
      end else begin
        points.valid <= 1'b0;
      end
    end
  end

  // The receiver stalls at random, also on the falling edge.
  always @(negedge clk) begin
    counts.ready <= !rst && ($urandom_range(99) >= receiver_stall_pct);
  end

  // --------------------------------------------------------------------------
  // Monitor. At each rising edge an accepted point is turned into a
  // prediction, and an accepted escape count is checked against the oldest
  // prediction. A count with nothing waiting for it is an error too.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : monitor
    escape_t want;
    took_point <= !rst && points.valid && points.ready;
    if (!rst && points.valid && points.ready) begin
      want.z0.re = points.start_real;
      want.z0.im = points.start_imag;
      want.count = escape_round(want.z0);
      pending_escapes.push_back(want);
      points_taken++;
      if (want.count == ((round_limit > MAX_LIMIT) ? MAX_LIMIT : round_limit)) begin
        bounded_points++;
      end
    end
    if (!rst && counts.valid && counts.ready) begin
      counts_checked++;
      if (pending_escapes.size() == 0) begin
        want = '0;
        note_mismatch("count with no point outstanding", want);
      end else begin
        want = pending_escapes.pop_front();
        if (counts.escape_count !== want.count) begin
          note_mismatch("wrong escape count", want);
        end
      end
    end
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("watchdog expired after %0d cycles with %0d results outstanding",
               cycle_count, pending_escapes.size());
      $display("tb: failure");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Test sequence.
  // --------------------------------------------------------------------------
  initial begin
    // Every block input is known from time zero.
    rst               = 1'b1;
    cfg_we            = 1'b0;
    cfg_index         = '0;
    cfg_data          = '0;
    points.valid      = 1'b0;
    points.start_real = '0;
    points.start_imag = '0;
    counts.ready      = 1'b0;
    repeat (6) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset defaults, c = -0.9 + 0.4i: the corners of the coordinate range,
    // the smallest nonzero steps, and a few ordinary points.
    queue_point('0, '0);
    queue_point(Q_MAX, Q_MAX);
    queue_point(Q_MIN, Q_MIN);
    queue_point(Q_MAX, Q_MIN);
    queue_point(Q_MIN, Q_MAX);
    queue_point(32'sd1, -32'sd1);
    queue_point(ONE, '0);
    queue_point('0, ONE);
    queue_point(-2 * ONE, '0);
    queue_point(to_q(0.3), to_q(0.5));
    run_points(IDLE_NONE);

    // A zero round limit: no round runs and every count is zero.
    set_julia('0, '0, '0, RADIUS_4);
    queue_point(ONE / 2, '0);
    queue_point(Q_MAX, Q_MIN);
    queue_point('0, '0);
    run_points(IDLE_BOTH);

    // Extreme constant, a single round and a zero radius: anything nonzero
    // after the first round escapes at once.
    set_julia(Q_MIN, Q_MAX, 11'd1, '0);
    queue_point('0, '0);
    queue_point(ONE, ONE);
    queue_point(-32'sd1, '0);
    run_points(IDLE_RECEIVER);

    // The opposite extreme constant, a limit beyond the supported one and the
    // largest radius.
    set_julia(Q_MAX, Q_MIN, {LIMIT_W{1'b1}}, {RADIUS_W{1'b1}});
    queue_point('0, '0);
    queue_point(Q_MIN, '0);
    queue_point(ONE, -ONE);
    run_points(IDLE_SENDER);

    // With c = 0 the origin and the unit circle never escape, so the clamped
    // limit itself comes back as the count.
    set_julia('0, '0, {LIMIT_W{1'b1}}, {RADIUS_W{1'b1}});
    queue_point('0, '0);
    queue_point(ONE, '0);
    run_points(IDLE_NONE);

    // Exactly the largest supported limit: two bounded points and one that
    // escapes after a few squarings.
    set_julia('0, '0, MAX_LIMIT, {RADIUS_W{1'b1}});
    queue_point('0, -ONE);
    queue_point(ONE / 2, ONE / 2);
    queue_point(2 * ONE, '0);
    run_points(IDLE_BOTH);

    // Random phases. The first goes back to the reset defaults; the others
    // draw a fresh setting. The idling pattern rotates from phase to phase.
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      if (phase == 0) begin
        set_julia(DEF_C_RE, DEF_C_IM, DEF_LIMIT, DEF_RADIUS);
      end else begin
        random_setting();
      end
      for (int n = 0; n < POINTS_PER_PHASE; n++) begin
        point_backlog.push_back(random_point());
      end
      run_points(idle_mode_t'(phase % 4));
    end

    // Give a stray extra result time to show up before judging the run.
    repeat (TAIL_CYCLES) @(negedge clk);

    $display("summary: %0d points over %0d register settings, %0d bounded and %0d escaped",
             points_taken, settings_used, bounded_points, points_taken - bounded_points);
    $display("summary: %0d counts checked, %0d mismatches, %0d cycles",
             counts_checked, mismatch_count, cycle_count);
    if (mismatch_count == 0 && pending_escapes.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
src/jet_pkg.sv
src/jet_if.sv
src/jet_cell.sv
src/jet_row.sv
src/julia_escape_time_top.sv
sim/tb_julia_escape_time_top.sv
